FILE: rtl/srtl_pkg.sv
package srtl_pkg;

	localparam int MAX_RANGES = 64;
	localparam int ADDR_BITS  = 48;
	localparam int SLOT_BITS  = 6;

	typedef enum logic [1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_ADD    = 2'd1,
		FUNC_LOOKUP = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	// one-hot sequencer states
	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_SREAD  = 8'b0000_0010,
		ST_SCMP   = 8'b0000_0100,
		ST_IREAD  = 8'b0000_1000,
		ST_ICMP   = 8'b0001_0000,
		ST_SHREAD = 8'b0010_0000,
		ST_SHWR   = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

endpackage

FILE: rtl/srtl_mem.sv
module srtl_mem #(
	parameter int DEPTH = srtl_pkg::MAX_RANGES,
	parameter int AW    = srtl_pkg::ADDR_BITS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [AW-1:0]            wstart,
	input  logic [AW-1:0]            wend,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [AW-1:0]            rstart,
	output logic [AW-1:0]            rend
);

	logic [2*AW-1:0] mem [DEPTH];

	// write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wstart, wend};
		end
		{rstart, rend} <= mem[raddr];
	end

endmodule

FILE: rtl/sorted_range_table_lookup.sv
// Channel   | Ports                                                   | Handshake
// command   | func, range_start, range_end, probe_address            | start & !busy
// result    | found, slot_index, table_full                           | done, one cycle
//
// Each item runs on one table memory with a single read and a single write port.
// Lookup: binary search, each step an entry read (SREAD) and compare (SCMP).
// Add: scan for position (IREAD, ICMP), shift later entries up (SHREAD, SHWR),
// then write the new range. Clear and unused codes go straight to DONE. Reset
// clears count, sequencer and result outputs. The receiver cannot stall results.
module sorted_range_table_lookup #(
	parameter int MAX_RANGES = srtl_pkg::MAX_RANGES,
	parameter int ADDR_BITS  = srtl_pkg::ADDR_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     func,
	input  logic [ADDR_BITS-1:0]           range_start,
	input  logic [ADDR_BITS-1:0]           range_end,
	input  logic [ADDR_BITS-1:0]           probe_address,
	output logic                           done,
	output logic                           found,
	output logic [srtl_pkg::SLOT_BITS-1:0] slot_index,
	output logic                           table_full
);

	localparam int IW = $clog2(MAX_RANGES);
	localparam int CW = $clog2(MAX_RANGES + 1);

	srtl_pkg::state_t state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] lo_q, hi_q, mid_q, pos_q, k_q;
	logic [ADDR_BITS-1:0] a_q, b_q;

	logic we;
	logic [IW-1:0] waddr, raddr;
	logic [ADDR_BITS-1:0] wstart, wend, rstart, rend;

	srtl_mem #(.DEPTH(MAX_RANGES), .AW(ADDR_BITS)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wstart(wstart), .wend(wend),
		.raddr(raddr), .rstart(rstart), .rend(rend)
	);

	// memory address and write data
	always_comb begin
		raddr  = mid_q[IW-1:0];
		we     = 1'b0;
		waddr  = k_q[IW-1:0];
		wstart = rstart;
		wend   = rend;
		case (state_q)
			srtl_pkg::ST_SREAD:  raddr = mid_q[IW-1:0];
			srtl_pkg::ST_IREAD:  raddr = pos_q[IW-1:0];
			srtl_pkg::ST_SHREAD: raddr = k_q[IW-1:0] - 1'b1;
			srtl_pkg::ST_SHWR: begin
				we = 1'b1;
				if (k_q == pos_q) begin
					wstart = a_q;
					wend   = b_q;
				end
			end
			default: raddr = mid_q[IW-1:0];
		endcase
	end

	assign busy = (state_q != srtl_pkg::ST_IDLE);

	// sequencer: hold item, advance search or insert, drop result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= srtl_pkg::ST_IDLE;
			count_q    <= '0;
			done       <= 1'b0;
			found      <= 1'b0;
			slot_index <= '0;
			table_full <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				srtl_pkg::ST_IDLE: begin
					if (start) begin
						found      <= 1'b0;
						slot_index <= '0;
						table_full <= 1'b0;
						lo_q       <= '0;
						hi_q       <= count_q - 1'b1;
						mid_q      <= '0;
						pos_q      <= '0;
						k_q        <= count_q;
						state_q    <= srtl_pkg::ST_DONE;
						case (func)
							srtl_pkg::FUNC_CLEAR: count_q <= '0;
							srtl_pkg::FUNC_ADD: begin
								a_q <= range_start;
								b_q <= range_end;
								if (count_q == CW'(MAX_RANGES))
									table_full <= 1'b1;
								else if (count_q == '0)
									state_q <= srtl_pkg::ST_SHWR;
								else
									state_q <= srtl_pkg::ST_IREAD;
							end
							srtl_pkg::FUNC_LOOKUP: begin
								a_q <= probe_address;
								if (count_q != '0) begin
									mid_q   <= CW'(({1'b0, count_q} - 1'b1) >> 1);
									state_q <= srtl_pkg::ST_SREAD;
								end
							end
							default: ;
						endcase
					end
				end
				srtl_pkg::ST_SREAD: state_q <= srtl_pkg::ST_SCMP;
				srtl_pkg::ST_SCMP: begin
					state_q <= srtl_pkg::ST_DONE;
					if (lo_q >= hi_q) begin
						// final single-entry check at lo
						if (lo_q < count_q && rstart <= a_q && a_q < rend) begin
							found      <= 1'b1;
							slot_index <= srtl_pkg::SLOT_BITS'(lo_q);
						end
					end else if (a_q < rstart) begin
						if (mid_q > lo_q) begin
							hi_q    <= mid_q - 1'b1;
							mid_q   <= CW'(({1'b0, lo_q} + {1'b0, mid_q} - 1'b1) >> 1);
							state_q <= srtl_pkg::ST_SREAD;
						end
					end else if (a_q >= rend) begin
						lo_q    <= mid_q + 1'b1;
						state_q <= srtl_pkg::ST_SREAD;
						if (mid_q + 1'b1 >= hi_q)
							mid_q <= mid_q + 1'b1;
						else
							mid_q <= CW'(({1'b0, mid_q} + 1'b1 + {1'b0, hi_q}) >> 1);
					end else begin
						found      <= 1'b1;
						slot_index <= srtl_pkg::SLOT_BITS'(mid_q);
					end
				end
				srtl_pkg::ST_IREAD: state_q <= srtl_pkg::ST_ICMP;
				srtl_pkg::ST_ICMP: begin
					// scan for first start above the new one
					if (rstart <= a_q) begin
						pos_q <= pos_q + 1'b1;
						if (pos_q + 1'b1 == count_q)
							state_q <= (k_q == pos_q + 1'b1) ? srtl_pkg::ST_SHWR
								: srtl_pkg::ST_SHREAD;
						else
							state_q <= srtl_pkg::ST_IREAD;
					end else begin
						state_q <= (k_q == pos_q) ? srtl_pkg::ST_SHWR : srtl_pkg::ST_SHREAD;
					end
				end
				srtl_pkg::ST_SHREAD: state_q <= srtl_pkg::ST_SHWR;
				srtl_pkg::ST_SHWR: begin
					if (k_q == pos_q) begin
						count_q <= count_q + 1'b1;
						state_q <= srtl_pkg::ST_DONE;
					end else begin
						k_q <= k_q - 1'b1;
						state_q <= (k_q - 1'b1 == pos_q) ? srtl_pkg::ST_SHWR
							: srtl_pkg::ST_SHREAD;
					end
				end
				srtl_pkg::ST_DONE: begin
					done    <= 1'b1;
					state_q <= srtl_pkg::ST_IDLE;
				end
				default: state_q <= srtl_pkg::ST_IDLE;
			endcase
		end
	end

endmodule
